// ===== hdl/buddy_block_allocator_top_macros.svh =====
// assertion macros shared by the buddy allocator modules
`ifndef BUDDY_BLOCK_ALLOCATOR_TOP_MACROS_SVH
`define BUDDY_BLOCK_ALLOCATOR_TOP_MACROS_SVH

// property holds on every clock edge out of reset
`define BBA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define BBA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/bba_pkg.sv =====
// types, constants and helpers of the buddy block allocator
`default_nettype none
package bba_pkg;

    localparam int NUM_CHUNKS_DEF = 256;
    localparam int ORD_W   = 4;
    localparam int ORD_N   = 16;
    localparam int SHIFT_W = 5;
    localparam int POOL_W  = 9;
    localparam int ADDR_W  = 32;
    localparam int BYTES_W = 25;
    localparam int CFG_IDX_W = 2;
    localparam int MAX_SHIFT = 16;

    localparam logic [SHIFT_W-1:0] SHIFT_RST = 5'd6;
    localparam logic [POOL_W-1:0]  POOL_RST  = 9'd256;

    localparam logic [CFG_IDX_W-1:0] REG_CHUNK_SHIFT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POOL_CHUNKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DATA_BASE   = 2'd2;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_NO_BLOCK    = 2'd1;
    localparam logic [1:0] ST_OUT_OF_POOL = 2'd2;
    localparam logic [1:0] ST_NOT_ALLOC   = 2'd3;

    localparam logic REQ_ALLOC = 1'b0;

    typedef struct packed {
        logic             free_h;
        logic             alloc_h;
        logic [ORD_W-1:0] ord;
    } t_entry;

    typedef enum logic [3:0] {
        OP_NOP, OP_RB_START, OP_RB_STEP, OP_LOAD, OP_NEED, OP_K_STEP, OP_SCAN_STEP,
        OP_PICK_STEP, OP_SPLIT_HEAD, OP_SPLIT_STEP, OP_FCHECK, OP_FHEAD, OP_MADDR,
        OP_MTEST, OP_MFINAL, OP_RESULT
    } t_dp_op;

    typedef struct packed {
        t_dp_op     op;
        logic [1:0] res_status;
    } t_dp_cmd;

    typedef struct packed {
        logic is_free;
        logic rb_last;
        logic k_done;
        logic k_big;
        logic scan_done;
        logic pick_hit;
        logic pick_end;
        logic split_done;
        logic out_pool;
        logic misalign;
        logic not_alloc;
        logic merge_stop;
        logic buddy_ok;
    } t_dp_stat;

    // block size in bytes for log2 size e, zero once it leaves the result width
    function automatic logic [BYTES_W-1:0] f_size(input logic [5:0] e);
        logic [BYTES_W-1:0] v;
        v = '0;
        if (e < 6'(BYTES_W)) begin
            v = BYTES_W'(1) << e;
        end
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/bba_ram.sv =====
// generic single-write, single-read ram with registered read data
`default_nettype none
module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== hdl/bba_dp.sv =====
// datapath: config registers, block map ram, scan, split and merge arithmetic
`default_nettype none
`include "buddy_block_allocator_top_macros.svh"
module bba_dp
    import bba_pkg::*;
#(
    parameter int NUM_CHUNKS = NUM_CHUNKS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [ADDR_W-1:0]    i_cfg_data,
    input  wire logic                 i_req_type,
    input  wire logic [ADDR_W-1:0]    i_req_bytes,
    input  wire logic [ADDR_W-1:0]    i_free_addr,
    input  wire t_dp_cmd              i_cmd,
    output t_dp_stat                  o_stat,
    output logic [1:0]                o_status,
    output logic [ADDR_W-1:0]         o_block_addr,
    output logic [BYTES_W-1:0]        o_granted,
    output logic [BYTES_W-1:0]        o_used
);
    localparam int AW = $clog2(NUM_CHUNKS);
    localparam int NW = $clog2(NUM_CHUNKS + 1);

    logic [SHIFT_W-1:0] r_shift;
    logic [POOL_W-1:0]  r_pool;
    logic [ADDR_W-1:0]  r_base;
    logic               r_type;
    logic [ADDR_W-1:0]  r_req, r_fa;
    logic [ADDR_W:0]    r_need;
    logic [5:0]         r_k;
    logic [NW-1:0]      r_idx, r_pos, r_rem;
    logic               r_rd_vld;
    logic [AW-1:0]      r_rd_idx;
    logic [ORD_N-1:0]   r_best_v;
    logic [AW-1:0]      r_best [ORD_N];
    logic [ORD_W-1:0]   r_j, r_o;
    logic [AW-1:0]      r_i, r_b;
    logic [BYTES_W-1:0] r_fbytes, r_used;

    logic [SHIFT_W-1:0] w_sh;
    logic [NW-1:0]      w_n;
    logic [ADDR_W-1:0]  w_mask, w_off;
    logic [47:0]        w_lim;
    logic [AW-1:0]      w_fidx, w_b;
    logic [ORD_W-1:0]   w_msb;
    logic               w_head;
    logic               w_we;
    logic [AW-1:0]      w_waddr, w_raddr;
    t_entry             w_wdata, w_rd;
    logic [BYTES_W-1:0] w_abytes;
    logic [BYTES_W:0]   w_sum;

    assign w_sh   = (r_shift > SHIFT_W'(MAX_SHIFT)) ? SHIFT_W'(MAX_SHIFT) : r_shift;
    assign w_n    = ({23'd0, r_pool} > 32'(NUM_CHUNKS)) ? NW'(NUM_CHUNKS) : NW'(r_pool);
    assign w_mask = (ADDR_W'(1) << w_sh) - ADDR_W'(1);
    assign w_off  = r_fa - r_base;
    assign w_lim  = 48'(w_n) << w_sh;
    assign w_fidx = AW'(w_off >> w_sh);
    assign w_b    = r_i ^ (AW'(1) << r_o);
    assign w_head = (r_rem != '0) && (r_idx == r_pos);
    assign w_abytes = f_size(r_k + 6'(w_sh));
    assign w_sum  = (BYTES_W + 1)'(r_used) + (BYTES_W + 1)'(w_abytes);

    always_comb begin
        w_msb = '0;
        for (int b = 0; b < NW; b++) begin
            if (r_rem[b]) begin
                w_msb = ORD_W'(b);
            end
        end
    end

    always_comb begin
        o_stat.is_free    = r_type;
        o_stat.rb_last    = (r_idx == NW'(NUM_CHUNKS - 1));
        o_stat.k_done     = (34'(1) << r_k) >= {1'b0, r_need};
        o_stat.k_big      = r_k > 6'(AW);
        o_stat.scan_done  = (r_idx >= w_n) && !r_rd_vld;
        o_stat.pick_hit   = r_best_v[r_j];
        o_stat.pick_end   = (r_j == ORD_W'(ORD_N - 1));
        o_stat.split_done = (r_j == r_k[ORD_W-1:0]);
        o_stat.out_pool   = 48'(w_off) >= w_lim;
        o_stat.misalign   = (w_off & w_mask) != '0;
        o_stat.not_alloc  = !w_rd.alloc_h;
        o_stat.merge_stop = (r_o >= ORD_W'(AW)) || (NW'(w_b) >= w_n);
        o_stat.buddy_ok   = w_rd.free_h && (w_rd.ord == r_o);
    end

    // ram port selection per datapath step
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_i;
        w_wdata = '0;
        w_raddr = r_idx[AW-1:0];
        case (i_cmd.op)
            OP_RB_START: ;
            OP_RB_STEP: begin
                w_we    = 1'b1;
                w_waddr = r_idx[AW-1:0];
                if (w_head) begin
                    w_wdata = '{free_h: 1'b1, alloc_h: 1'b0, ord: w_msb};
                end
            end
            OP_SPLIT_HEAD: begin
                w_we    = 1'b1;
                w_wdata = '{free_h: 1'b0, alloc_h: 1'b1, ord: r_k[ORD_W-1:0]};
            end
            OP_SPLIT_STEP: begin
                w_we    = 1'b1;
                w_waddr = r_i + (AW'(1) << (r_j - ORD_W'(1)));
                w_wdata = '{free_h: 1'b1, alloc_h: 1'b0, ord: r_j - ORD_W'(1)};
            end
            OP_FCHECK: w_raddr = w_fidx;
            OP_FHEAD: begin
                w_we    = w_rd.alloc_h;
                w_wdata = '{free_h: 1'b0, alloc_h: 1'b0, ord: w_rd.ord};
            end
            OP_MADDR: w_raddr = w_b;
            OP_MTEST: begin
                w_we    = o_stat.buddy_ok;
                w_waddr = r_b;
                w_wdata = '{free_h: 1'b0, alloc_h: w_rd.alloc_h, ord: w_rd.ord};
            end
            OP_MFINAL: begin
                w_we    = 1'b1;
                w_wdata = '{free_h: 1'b1, alloc_h: 1'b0, ord: r_o};
            end
            default: ;
        endcase
    end

    bba_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (NUM_CHUNKS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift  <= SHIFT_RST;
            r_pool   <= POOL_RST;
            r_base   <= '0;
            r_idx    <= '0;
            r_rd_vld <= 1'b0;
            r_best_v <= '0;
            r_used   <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_CHUNK_SHIFT: r_shift <= i_cfg_data[SHIFT_W-1:0];
                    REG_POOL_CHUNKS: r_pool  <= i_cfg_data[POOL_W-1:0];
                    REG_DATA_BASE:   r_base  <= i_cfg_data;
                    default: ;
                endcase
            end
            case (i_cmd.op)
                OP_RB_START: begin
                    r_idx  <= '0;
                    r_pos  <= '0;
                    r_rem  <= w_n;
                    r_used <= '0;
                end
                OP_RB_STEP: begin
                    r_idx <= r_idx + NW'(1);
                    if (w_head) begin
                        r_pos <= r_pos + (NW'(1) << w_msb);
                        r_rem[w_msb] <= 1'b0;
                    end
                end
                OP_LOAD: begin
                    r_type <= i_req_type;
                    r_req  <= i_req_bytes;
                    r_fa   <= i_free_addr;
                end
                OP_NEED: begin
                    r_need   <= ((ADDR_W + 1)'(r_req) + (ADDR_W + 1)'(w_mask)) >> w_sh;
                    r_k      <= '0;
                    r_idx    <= '0;
                    r_rd_vld <= 1'b0;
                    r_best_v <= '0;
                end
                OP_K_STEP: begin
                    if (!o_stat.k_done) begin
                        r_k <= r_k + 6'd1;
                    end
                end
                OP_SCAN_STEP: begin
                    if (r_idx < w_n) begin
                        r_idx    <= r_idx + NW'(1);
                        r_rd_vld <= 1'b1;
                        r_rd_idx <= r_idx[AW-1:0];
                    end else begin
                        r_rd_vld <= 1'b0;
                    end
                    // first hit per order is the lowest address
                    if (r_rd_vld && w_rd.free_h && !r_best_v[w_rd.ord]) begin
                        r_best_v[w_rd.ord] <= 1'b1;
                        r_best[w_rd.ord]   <= r_rd_idx;
                    end
                    if (o_stat.scan_done) begin
                        r_j <= r_k[ORD_W-1:0];
                    end
                end
                OP_PICK_STEP: begin
                    if (o_stat.pick_hit) begin
                        r_i <= r_best[r_j];
                    end else if (!o_stat.pick_end) begin
                        r_j <= r_j + ORD_W'(1);
                    end
                end
                OP_SPLIT_STEP: r_j <= r_j - ORD_W'(1);
                OP_FCHECK: r_i <= w_fidx;
                OP_FHEAD: begin
                    r_o      <= w_rd.ord;
                    r_fbytes <= f_size(6'(w_rd.ord) + 6'(w_sh));
                end
                OP_MADDR: r_b <= w_b;
                OP_MTEST: begin
                    if (o_stat.buddy_ok) begin
                        if (r_b < r_i) begin
                            r_i <= r_b;
                        end
                        r_o <= r_o + ORD_W'(1);
                    end
                end
                OP_RESULT: begin
                    o_status <= i_cmd.res_status;
                    if (i_cmd.res_status != ST_OK) begin
                        o_block_addr <= '0;
                        o_granted    <= '0;
                    end else if (r_type == REQ_ALLOC) begin
                        o_block_addr <= r_base + (ADDR_W'(r_i) << w_sh);
                        o_granted    <= w_abytes;
                        r_used       <= w_sum[BYTES_W] ? '1 : w_sum[BYTES_W-1:0];
                    end else begin
                        o_block_addr <= r_fa;
                        o_granted    <= r_fbytes;
                        r_used       <= (r_used > r_fbytes) ? r_used - r_fbytes : '0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_used = r_used;

    `BBA_ASSERT(a_scan_bound, i_cmd.op != OP_SCAN_STEP || r_idx <= w_n, "scan index ran past pool")
    `BBA_ASSERT(a_split_above, i_cmd.op != OP_SPLIT_STEP || r_j > r_k[ORD_W-1:0], "split below requested order")
    `BBA_ASSERT_NEXT(a_merge_order, i_cmd.op == OP_MTEST && o_stat.buddy_ok, r_o <= ORD_W'(AW), "merged block larger than memory")
endmodule
`default_nettype wire

// ===== hdl/bba_ctrl.sv =====
// controller: sequences rebuild, allocate and free steps of the datapath
`default_nettype none
`include "buddy_block_allocator_top_macros.svh"
module bba_ctrl
    import bba_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_rebuild,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);
    typedef enum logic [3:0] {
        S_RB_INIT, S_RB, S_IDLE, S_NEED, S_KCALC, S_SCAN, S_PICK, S_SPLIT_HEAD, S_SPLIT,
        S_FCHECK, S_FHEAD, S_MADDR, S_MTEST, S_MFINAL, S_RESULT
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_res, n_res;
    logic       r_out_valid, n_out_valid;

    assign o_in_ready  = (r_state == S_IDLE) && !i_rebuild;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state         = r_state;
        n_res           = r_res;
        n_out_valid     = r_out_valid && !i_out_ready;
        o_cmd.op        = OP_NOP;
        o_cmd.res_status = r_res;
        case (r_state)
            S_RB_INIT: begin
                o_cmd.op = OP_RB_START;
                n_state  = S_RB;
            end
            S_RB: begin
                o_cmd.op = OP_RB_STEP;
                if (i_rebuild) begin
                    n_state = S_RB_INIT;
                end else if (i_stat.rb_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_rebuild) begin
                    n_state = S_RB_INIT;
                end else if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_NEED;
                end
            end
            S_NEED: begin
                if (i_stat.is_free) begin
                    n_state = S_FCHECK;
                end else begin
                    o_cmd.op = OP_NEED;
                    n_state  = S_KCALC;
                end
            end
            S_KCALC: begin
                o_cmd.op = OP_K_STEP;
                if (i_stat.k_big) begin
                    n_res   = ST_NO_BLOCK;
                    n_state = S_RESULT;
                end else if (i_stat.k_done) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.op = OP_SCAN_STEP;
                if (i_stat.scan_done) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                o_cmd.op = OP_PICK_STEP;
                if (i_stat.pick_hit) begin
                    n_state = S_SPLIT_HEAD;
                end else if (i_stat.pick_end) begin
                    n_res   = ST_NO_BLOCK;
                    n_state = S_RESULT;
                end
            end
            S_SPLIT_HEAD: begin
                o_cmd.op = OP_SPLIT_HEAD;
                n_state  = S_SPLIT;
            end
            S_SPLIT: begin
                if (i_stat.split_done) begin
                    n_res   = ST_OK;
                    n_state = S_RESULT;
                end else begin
                    o_cmd.op = OP_SPLIT_STEP;
                end
            end
            S_FCHECK: begin
                o_cmd.op = OP_FCHECK;
                if (i_stat.out_pool) begin
                    n_res   = ST_OUT_OF_POOL;
                    n_state = S_RESULT;
                end else if (i_stat.misalign) begin
                    n_res   = ST_NOT_ALLOC;
                    n_state = S_RESULT;
                end else begin
                    n_state = S_FHEAD;
                end
            end
            S_FHEAD: begin
                o_cmd.op = OP_FHEAD;
                if (i_stat.not_alloc) begin
                    n_res   = ST_NOT_ALLOC;
                    n_state = S_RESULT;
                end else begin
                    n_state = S_MADDR;
                end
            end
            S_MADDR: begin
                o_cmd.op = OP_MADDR;
                n_state  = i_stat.merge_stop ? S_MFINAL : S_MTEST;
            end
            S_MTEST: begin
                o_cmd.op = OP_MTEST;
                n_state  = i_stat.buddy_ok ? S_MADDR : S_MFINAL;
            end
            S_MFINAL: begin
                o_cmd.op = OP_MFINAL;
                n_res    = ST_OK;
                n_state  = S_RESULT;
            end
            S_RESULT: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.op    = OP_RESULT;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RB_INIT;
            r_res       <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res       <= n_res;
            r_out_valid <= n_out_valid;
        end
    end

    `BBA_ASSERT_NEXT(a_busy_after_take, i_in_valid && o_in_ready, !o_in_ready, "took a word while busy")
    `BBA_ASSERT(a_result_room, o_cmd.op != OP_RESULT || !r_out_valid || i_out_ready, "result overwrote pending word")
    `BBA_ASSERT(a_valid_source, !$rose(r_out_valid) || $past(r_state) == S_RESULT, "output word from nowhere")
endmodule
`default_nettype wire

// ===== hdl/buddy_block_allocator_top.sv =====
// Binary buddy allocator over a pool of equal chunks.
// Requests enter on the s_axis channel: tuser is the request kind (0 allocate, 1 free),
// tdata holds the byte count and the address to free. Each request gives one word on
// m_axis: tuser is the status code, tdata the block address, block bytes and used total.
// The block map lives in a single ram of NUM_CHUNKS entries.
// After reset, and after every write of pool_chunks, a rebuild pass walks the whole ram,
// one entry per cycle, with s_axis_tready low.
// For an allocate, the free-block scan reads one ram entry per cycle.
// A free checks its address, then the block head, then merges upward; each buddy merge is
// a ram read then a write, and a free refused for its address answers before its head is read.
// One request is in flight at a time; the result sits in an output register, so the next
// request is taken while the last result still waits. If the receiver stalls, the next
// result waits in its final step until the output register empties.
// Configuration writes are taken at any time but are meant for an idle block.
`default_nettype none
module buddy_block_allocator_top
    import bba_pkg::*;
#(
    parameter int NUM_CHUNKS = NUM_CHUNKS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [ADDR_W-1:0]    i_cfg_data,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [63:0]          s_axis_tdata,  // request_bytes, free_address
    input  wire logic                 s_axis_tuser,  // req_type
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [87:0]               m_axis_tdata,  // block_address, granted_bytes, used_bytes
    output logic [1:0]                m_axis_tuser   // status
);
    t_dp_cmd            w_cmd;
    t_dp_stat           w_stat;
    logic [ADDR_W-1:0]  w_addr;
    logic [BYTES_W-1:0] w_granted, w_used;

    bba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rebuild   (i_cfg_we && (i_cfg_idx == REG_POOL_CHUNKS)),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    bba_dp #(
        .NUM_CHUNKS (NUM_CHUNKS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_req_type   (s_axis_tuser),
        .i_req_bytes  (s_axis_tdata[31:0]),
        .i_free_addr  (s_axis_tdata[63:32]),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .o_status     (m_axis_tuser),
        .o_block_addr (w_addr),
        .o_granted    (w_granted),
        .o_used       (w_used)
    );

    assign m_axis_tdata = {6'd0, w_used, w_granted, w_addr};
endmodule
`default_nettype wire

// ===== bench/bba_checker.sv =====
// scoreboard for the buddy block allocator: predicts each result and compares it
`timescale 1ns / 1ps
module bba_checker
    import bba_pkg::*;
#(
    parameter int NUM_CHUNKS = NUM_CHUNKS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ADDR_W-1:0]    i_cfg_data,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [63:0]          s_axis_tdata,  // request_bytes, free_address
    input  logic                 s_axis_tuser,  // req_type
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [87:0]          m_axis_tdata,  // block_address, granted_bytes, used_bytes
    input  logic [1:0]           m_axis_tuser,  // status
    output int                   o_mismatches,
    output int                   o_awaiting
);

    localparam logic [BYTES_W-1:0] USED_SAT = '1;

    typedef struct {
        logic [1:0]         status;
        logic [ADDR_W-1:0]  addr;
        logic [BYTES_W-1:0] bytes;
        logic [BYTES_W-1:0] used;
    } t_outcome;

    logic [SHIFT_W-1:0] shift_reg;
    logic [POOL_W-1:0]  pool_reg;
    logic [ADDR_W-1:0]  base_reg;
    logic               is_free [NUM_CHUNKS];
    logic               is_held [NUM_CHUNKS];
    logic [ORD_W-1:0]   order_of [NUM_CHUNKS];
    logic [BYTES_W-1:0] used_total;
    t_outcome           expected_results[$];

    initial begin
        o_mismatches = 0;
        o_awaiting   = 0;
    end

    function automatic int pool_len();
        return (pool_reg > NUM_CHUNKS) ? NUM_CHUNKS : int'(pool_reg);
    endfunction

    function automatic int shift_len();
        return (shift_reg > MAX_SHIFT) ? MAX_SHIFT : int'(shift_reg);
    endfunction

    // split the pool into aligned power-of-two blocks, largest first
    function automatic void split_pool();
        int n;
        int pos;
        n = pool_len();
        pos = 0;
        for (int c = 0; c < NUM_CHUNKS; c++) begin
            is_free[c]  = 1'b0;
            is_held[c]  = 1'b0;
            order_of[c] = '0;
        end
        used_total = '0;
        for (int o = ORD_N - 1; o >= 0; o--) begin
            if (n[o]) begin
                if (pos < NUM_CHUNKS) begin
                    is_free[pos]  = 1'b1;
                    order_of[pos] = ORD_W'(o);
                end
                pos += (1 << o);
            end
        end
    endfunction

    function automatic int lowest_free(int ord);
        for (int c = 0; c < pool_len(); c++) begin
            if (is_free[c] && order_of[c] == ORD_W'(ord)) return c;
        end
        return -1;
    endfunction

    function automatic t_outcome serve_request(logic kind, logic [31:0] req,
                                               logic [31:0] fa);
        t_outcome r;
        int sh, n, k, j, found, i, o, b;
        logic [63:0] need;
        logic [63:0] sz;
        logic [31:0] off;
        r = '{ST_OK, '0, '0, '0};
        sh = shift_len();
        n = pool_len();
        found = -1;
        j = 0;
        if (kind == REQ_ALLOC) begin
            need = (64'(req) + ((64'd1 << sh) - 64'd1)) >> sh;
            if (need == 0) need = 1;
            k = 0;
            while (k < 40 && (64'd1 << k) < need) k++;
            if (k < ORD_N) begin
                for (j = k; j < ORD_N; j++) begin
                    found = lowest_free(j);
                    if (found >= 0) break;
                end
            end
            if (found < 0) begin
                r.status = ST_NO_BLOCK;
            end else begin
                i = found;
                is_free[i] = 1'b0;
                while (j > k) begin
                    j--;
                    if (i + (1 << j) < NUM_CHUNKS) begin
                        is_free[i + (1 << j)]  = 1'b1;
                        order_of[i + (1 << j)] = ORD_W'(j);
                    end
                end
                is_held[i]  = 1'b1;
                order_of[i] = ORD_W'(k);
                sz = 64'd1 << (k + sh);
                r.bytes = sz[BYTES_W-1:0];
                r.addr  = base_reg + 32'(64'(i) << sh);
                used_total = (26'(used_total) + 26'(r.bytes) > 26'(USED_SAT)) ?
                             USED_SAT : used_total + r.bytes;
            end
        end else begin
            off = fa - base_reg;
            if (64'(off) >= (64'(n) << sh)) begin
                r.status = ST_OUT_OF_POOL;
            end else if ((off & ((32'd1 << sh) - 32'd1)) != 0 || !is_held[off >> sh]) begin
                r.status = ST_NOT_ALLOC;
            end else begin
                i = int'(off >> sh);
                o = int'(order_of[i]);
                sz = 64'd1 << (o + sh);
                r.bytes = sz[BYTES_W-1:0];
                r.addr  = fa;
                used_total = (used_total > r.bytes) ? used_total - r.bytes : '0;
                is_held[i] = 1'b0;
                // merge upward while the buddy is a whole free block of the same order
                while (o < ORD_N - 1) begin
                    b = i ^ (1 << o);
                    if (b >= n || !is_free[b] || order_of[b] != ORD_W'(o)) break;
                    is_free[b] = 1'b0;
                    if (b < i) i = b;
                    o++;
                end
                is_free[i]  = 1'b1;
                order_of[i] = ORD_W'(o);
            end
        end
        r.used = used_total;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch in %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
        o_mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_outcome w;
        if (!i_rst_n) begin
            shift_reg = SHIFT_RST;
            pool_reg  = POOL_RST;
            base_reg  = '0;
            split_pool();
            expected_results.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    // no word was outstanding
                    report_mismatch("unexpected result word", 32'(m_axis_tuser), 32'd0);
                end else begin
                    w = expected_results.pop_front();
                    if (m_axis_tuser != w.status)
                        report_mismatch("status", 32'(m_axis_tuser), 32'(w.status));
                    if (m_axis_tdata[31:0] != w.addr)
                        report_mismatch("block_address", m_axis_tdata[31:0], w.addr);
                    if (m_axis_tdata[56:32] != w.bytes)
                        report_mismatch("granted_bytes", 32'(m_axis_tdata[56:32]),
                                        32'(w.bytes));
                    if (m_axis_tdata[81:57] != w.used)
                        report_mismatch("used_bytes", 32'(m_axis_tdata[81:57]), 32'(w.used));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_results.push_back(serve_request(s_axis_tuser, s_axis_tdata[31:0],
                                                         s_axis_tdata[63:32]));
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_CHUNK_SHIFT: shift_reg = i_cfg_data[SHIFT_W-1:0];
                    REG_POOL_CHUNKS: begin
                        pool_reg = i_cfg_data[POOL_W-1:0];
                        split_pool();
                    end
                    REG_DATA_BASE: base_reg = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_awaiting = expected_results.size();
    end

endmodule

// ===== bench/tb_buddy_block_allocator_top.sv =====
// testbench top for the buddy block allocator: stimulus, handshake idling and verdict
`timescale 1ns / 1ps
module tb_buddy_block_allocator_top;
    import bba_pkg::*;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [ADDR_W-1:0]    i_cfg_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [63:0]          s_axis_tdata;  // request_bytes, free_address
    logic                 s_axis_tuser;  // req_type
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [87:0]          m_axis_tdata;  // block_address, granted_bytes, used_bytes
    logic [1:0]           m_axis_tuser;  // status
    int                   mismatches;
    int                   awaiting;

    int          words_sent, words_back;
    int          alloc_ok, free_ok, refused;
    bit          send_idle, recv_idle;
    int          cur_shift, cur_pool;
    logic [31:0] cur_base;
    logic        kinds_sent[$];
    logic [31:0] held_addrs[$];
    logic [31:0] last_freed;

    buddy_block_allocator_top i_dut (.*);

    bba_checker i_chk (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
        .o_mismatches(mismatches), .o_awaiting(awaiting)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    initial begin
        #60ms;
        $display("timeout");
        $display("FAILED: results differ");
        $finish;
    end

    // collect granted addresses so that frees can hit live blocks
    always @(posedge i_clk) begin
        logic kind;
        if (m_axis_tvalid && m_axis_tready) begin
            words_back++;
            kind = kinds_sent.pop_front();
            if (m_axis_tuser != ST_OK) begin
                refused++;
            end else if (kind == REQ_ALLOC) begin
                alloc_ok++;
                held_addrs.push_back(m_axis_tdata[31:0]);
            end else begin
                free_ok++;
            end
        end
    end

    // receiver: random stall before every word while recv_idle is set
    initial begin
        int w;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            w = recv_idle ? $urandom_range(0, 11) : 0;
            repeat (w) begin
                m_axis_tready <= 1'b0;
                @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_word(logic kind, logic [31:0] req, logic [31:0] fa);
        int gap;
        gap = send_idle ? $urandom_range(0, 11) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {fa, req};
        do @(posedge i_clk); while (!s_axis_tready);
        kinds_sent.push_back(kind);
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (words_back != words_sent) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_pool(int shift_v, int pool_v, logic [31:0] base_v);
        write_reg(REG_CHUNK_SHIFT, 32'(shift_v));
        write_reg(REG_DATA_BASE, base_v);
        write_reg(REG_POOL_CHUNKS, 32'(pool_v));
        cur_shift = (shift_v > MAX_SHIFT) ? MAX_SHIFT : shift_v;
        cur_pool  = (pool_v > 256) ? 256 : pool_v;
        cur_base  = base_v;
        held_addrs.delete();
    endtask

    task automatic random_requests(int count);
        int r, pick;
        logic [63:0] chunk;
        logic [31:0] req, fa;
        chunk = 64'd1 << cur_shift;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 45 && (held_addrs.size() > 0 || r < 10)) begin
                pick = $urandom_range(0, 99);
                if (pick < 75 && held_addrs.size() > 0) begin
                    r = $urandom_range(0, held_addrs.size() - 1);
                    fa = held_addrs[r];
                    held_addrs.delete(r);
                    last_freed = fa;
                end else if (pick < 82) begin
                    fa = last_freed;
                end else if (pick < 88) begin
                    fa = cur_base + 32'($urandom_range(0, cur_pool) * chunk);
                end else if (pick < 93) begin
                    fa = cur_base + 32'($urandom_range(1, 2));
                end else begin
                    fa = $urandom;
                end
                send_word(1'b1, $urandom, fa);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 60)      req = 32'($urandom_range(0, 32'(4 * chunk)));
                else if (r < 85) req = 32'($urandom_range(0, 32'(32 * chunk)));
                else if (r < 95) req = 32'($urandom_range(0, 32'(chunk * cur_pool)));
                else             req = $urandom;
                send_word(1'b0, req, $urandom);
            end
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = REG_CHUNK_SHIFT;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser  = REQ_ALLOC;
        s_axis_tdata  = '0;
        send_idle     = 1'b0;
        recv_idle     = 1'b0;
        cur_shift     = 6;
        cur_pool      = 256;
        cur_base      = '0;
        last_freed    = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: sizes at the edges, bad frees, whole pool
        send_word(1'b0, 32'd0, 32'd0);
        send_word(1'b0, 32'd1, 32'hFFFF_FFFF);
        send_word(1'b0, 32'd64, 32'd0);
        send_word(1'b0, 32'd65, 32'd0);
        send_word(1'b0, 32'hFFFF_FFFF, 32'd0);
        send_word(1'b0, 32'd16384, 32'd0);
        send_word(1'b1, 32'd0, 32'd32);
        send_word(1'b1, 32'd0, 32'h4000);
        send_word(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(1'b1, 32'd0, 32'd0);
        send_word(1'b1, 32'd0, 32'd0);
        send_word(1'b1, 32'd0, 32'd64);
        send_word(1'b1, 32'd0, 32'd128);
        send_word(1'b1, 32'd0, 32'd256);
        send_word(1'b0, 32'd16384, 32'd0);
        send_word(1'b1, 32'd0, 32'd0);
        send_word(1'b0, 32'd8192, 32'd0);
        send_word(1'b0, 32'd8193, 32'd0);
        drain();
        held_addrs.delete();

        recv_idle = 1'b1;
        random_requests(120);
        // hold off until every result is back, then go on
        drain();
        send_idle = 1'b1;
        random_requests(150);
        drain();

        write_reg(2'd3, 32'hFFFF_FFFF);
        set_pool(0, 1, 32'hFFFF_FFFF);
        random_requests(200);
        drain();

        send_idle = 1'b0;
        set_pool(16, 511, 32'hFFFF_0000);
        random_requests(250);
        drain();

        // shift moved while blocks are held
        write_reg(REG_CHUNK_SHIFT, 32'd31);
        random_requests(150);
        drain();
        write_reg(REG_CHUNK_SHIFT, 32'd5);
        cur_shift = 5;
        random_requests(100);
        drain();

        recv_idle = 1'b0;
        send_idle = 1'b1;
        set_pool(3, 0, 32'h0000_1000);
        random_requests(80);
        drain();

        recv_idle = 1'b1;
        set_pool(2, 100, 32'h1234_5678);
        random_requests(300);
        drain();

        send_idle = 1'b0;
        recv_idle = 1'b0;
        set_pool(6, 256, 32'h0);
        random_requests(430);
        drain();
        repeat (40) @(negedge i_clk);

        $display("%0d requests: %0d allocations granted, %0d blocks freed, %0d refused",
                 words_sent, alloc_ok, free_ok, refused);
        $display("pools of 0 to 256 chunks, chunk shifts 0 to 31, wrapping base addresses");
        if (mismatches == 0 && awaiting == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, awaiting);
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/bba_pkg.sv
hdl/bba_ram.sv
hdl/bba_dp.sv
hdl/bba_ctrl.sv
hdl/buddy_block_allocator_top.sv
bench/bba_checker.sv
bench/tb_buddy_block_allocator_top.sv
